/* design/sed_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_pkg: shared types and constants of the string escape decoder
// Word types of both channels, controller/datapath command and status
// groups, character codes and the hex and UTF-8 helper functions.
// ----------------------------------------------------------------------------
package sed_pkg;

	// Width of the result counters. It covers the abandon run of a brace escape
	// of up to twenty-nine digits (the digits plus letter and brace).
	localparam int CNT_W = 5;

	// Code point limits.
	localparam logic [20:0] CP_LIMIT     = 21'h10FFFF;
	localparam logic [20:0] CP_BAD       = 21'h110000;
	localparam logic [20:0] CP_SHIFT_MAX = 21'h011000;
	localparam logic [20:0] CP_REPLACE   = 21'h00FFFD;

	// Character codes.
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A_LO   = 8'h61;
	localparam logic [7:0] CH_F_LO   = 8'h66;
	localparam logic [7:0] CH_A_UP   = 8'h41;
	localparam logic [7:0] CH_F_UP   = 8'h46;

	// Control bytes produced by the single letter escapes.
	localparam logic [7:0] CTL_LF  = 8'h0A;
	localparam logic [7:0] CTL_TAB = 8'h09;
	localparam logic [7:0] CTL_CR  = 8'h0D;
	localparam logic [7:0] CTL_VT  = 8'h0B;
	localparam logic [7:0] CTL_FF  = 8'h0C;
	localparam logic [7:0] CTL_BS  = 8'h08;

	// Input and result words.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       body_end;
	} sed_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
	} sed_out_t;

	// Escape decoding mode.
	typedef enum logic [2:0] {
		MODE_PLAIN  = 3'd0,
		MODE_ESC    = 3'd1,
		MODE_OCT    = 3'd2,
		MODE_HEX    = 3'd3,
		MODE_USTART = 3'd4,
		MODE_UFIXED = 3'd5,
		MODE_UBRACE = 3'd6
	} sed_mode_t;

	// Controller states: idle, then one state per result segment.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ABANDON,
		ST_VALUE,
		ST_TAIL
	} sed_state_t;

	// Result segment selected by the controller.
	typedef enum logic [1:0] {
		SEG_AB,
		SEG_VAL,
		SEG_TAIL
	} sed_seg_t;

	// Result plan of one input word: abandon run, value bytes, tail byte.
	typedef struct packed {
		logic [CNT_W-1:0] ab_len;
		logic [2:0]       val_len;
		logic             tail_en;
		logic             body_end;
	} sed_plan_t;

	// Status from datapath to controller.
	typedef struct packed {
		sed_plan_t nxt;
		sed_plan_t cur;
		logic      slot_free;
	} sed_stat_t;

	// Command from controller to datapath.
	typedef struct packed {
		logic             take;
		logic             load;
		sed_seg_t         seg;
		logic [CNT_W-1:0] idx;
		logic             last;
		logic             done;
	} sed_cmd_t;

	// UTF-8 encoding of one code point; bytes[0] goes out first.
	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] bytes;
	} sed_utf8_t;

	// Hex digit decode: bit 4 is the valid flag, bits 3:0 the value.
	function automatic logic [4:0] sed_hex(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r = {1'b1, 4'(c - CH_ZERO)};
		end else if (c >= CH_A_LO && c <= CH_F_LO) begin
			r = {1'b1, 4'(c - CH_A_LO + 8'd10)};
		end else if (c >= CH_A_UP && c <= CH_F_UP) begin
			r = {1'b1, 4'(c - CH_A_UP + 8'd10)};
		end
		return r;
	endfunction

	// Encode a code point as UTF-8; values above the limit give U+FFFD.
	function automatic sed_utf8_t sed_utf8(input logic [20:0] cp_in);
		logic [20:0] cp;
		sed_utf8_t   r;
		cp = (cp_in > CP_LIMIT) ? CP_REPLACE : cp_in;
		r.bytes = '0;
		if (cp < 21'h80) begin
			r.len = 3'd1;
			r.bytes[0] = {1'b0, cp[6:0]};
		end else if (cp < 21'h800) begin
			r.len = 3'd2;
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.len = 3'd3;
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			r.len = 3'd4;
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

/* design/string_escape_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_escape_decoder_core: string literal escape decoder
// Decodes string body bytes with backslash escapes (single letter, octal,
// \x, \u and \u{...}) into output bytes, UTF-8 for code points.
// ----------------------------------------------------------------------------
//  Channel | Word       | Handshake            | Direction
//  src     | sed_in_t   | src_valid/src_stall  | into the block
//  dst     | sed_out_t  | dst_valid/dst_stall  | out of the block
//
//  A word is taken while the controller is idle; its result bytes then follow
//  at one byte per cycle while dst_stall lets them go, and no new word is
//  taken until the last of them is loaded into the single output register.
//  src_stall is high while the controller still has result bytes to load.
//  dst_stall holds the output register and pauses the controller.
//  Reset is asynchronous; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
module string_escape_decoder_core
	import sed_pkg::*;
#(
	parameter int MAX_BRACE_DIGITS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	output logic     src_stall,
	input  sed_in_t  src_data,
	output logic     dst_valid,
	input  logic     dst_stall,
	output sed_out_t dst_data
);

	sed_cmd_t  cmd;
	sed_stat_t stat;

	// Controller.
	sed_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath.
	sed_datapath #(
		.MAX_BRACE_DIGITS (MAX_BRACE_DIGITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (src_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_stall (dst_stall),
		.out_valid (dst_valid),
		.out_data  (dst_data)
	);

endmodule

/* design/sed_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_ctrl: controller of the string escape decoder
// Takes one input word while idle, then walks the result plan segment by
// segment, loading one result byte per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
module sed_ctrl
	import sed_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  sed_stat_t stat,
	output sed_cmd_t  cmd
);

	sed_state_t       state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;

	// State and byte index registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// Input is taken only while no result of the previous word is pending.
	assign src_stall = (state_q != ST_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cmd      = '0;
		cmd.seg  = SEG_AB;
		cmd.idx  = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (src_valid) begin
					cmd.take = 1'b1;
					idx_d    = '0;
					if (stat.nxt.ab_len != '0) begin
						state_d = ST_ABANDON;
					end else if (stat.nxt.val_len != '0) begin
						state_d = ST_VALUE;
					end else if (stat.nxt.tail_en) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_ABANDON: begin
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					cmd.seg  = SEG_AB;
					if (idx_q + CNT_W'(1) == stat.cur.ab_len) begin
						idx_d    = '0;
						cmd.last = (stat.cur.val_len == '0) && !stat.cur.tail_en;
						if (stat.cur.val_len != '0) begin
							state_d = ST_VALUE;
						end else if (stat.cur.tail_en) begin
							state_d = ST_TAIL;
						end else begin
							state_d = ST_IDLE;
						end
					end else begin
						idx_d = idx_q + CNT_W'(1);
					end
				end
			end
			ST_VALUE: begin
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					cmd.seg  = SEG_VAL;
					if (idx_q + CNT_W'(1) == CNT_W'(stat.cur.val_len)) begin
						idx_d    = '0;
						cmd.last = !stat.cur.tail_en;
						state_d  = stat.cur.tail_en ? ST_TAIL : ST_IDLE;
					end else begin
						idx_d = idx_q + CNT_W'(1);
					end
				end
			end
			ST_TAIL: begin
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					cmd.seg  = SEG_TAIL;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cmd.done = cmd.last && stat.cur.body_end;
	end

endmodule

/* design/sed_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_datapath: escape state, held digits and output register
// Decodes one input word against the escape state into a result plan
// (abandon run, value bytes, tail byte) and drives result bytes on command.
// ----------------------------------------------------------------------------
module sed_datapath
	import sed_pkg::*;
#(
	parameter int MAX_BRACE_DIGITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  sed_in_t   in_data,
	input  sed_cmd_t  cmd,
	output sed_stat_t stat,
	input  logic      out_stall,
	output logic      out_valid,
	output sed_out_t  out_data
);

	localparam int CW  = $clog2(MAX_BRACE_DIGITS + 1);
	localparam int DIW = $clog2(MAX_BRACE_DIGITS);

	// Escape state.
	sed_mode_t   mode_q;
	logic [CW-1:0] cnt_q;
	logic [20:0] cv_q;
	logic [7:0]  held_q [MAX_BRACE_DIGITS];

	// Registered plan of the word being emitted.
	sed_plan_t       plan_q;
	logic [7:0]      letter_q;
	logic            brace_q;
	logic [3:0][7:0] val_q;
	logic [7:0]      tail_q;

	// Output register.
	logic     out_valid_q;
	sed_out_t out_q;

	// Decode signals.
	logic [7:0]    b;
	logic [4:0]    hx;
	logic          is_oct;
	logic [8:0]    oct3;
	logic [24:0]   shifted;
	sed_mode_t     m_mode;
	logic [CW-1:0] m_cnt;
	logic [20:0]   m_cv;
	logic          hold_en;
	logic          ab_en;
	logic          ab_u;
	logic          ab_br;
	logic [CW-1:0] ab_cnt;
	logic          val_en;
	logic          val_utf;
	logic [20:0]   val_word;
	logic          plain_go;
	logic          tail_en;
	logic [7:0]    tail_byte;
	sed_utf8_t     utf;
	sed_plan_t     plan_d;
	logic [3:0][7:0] val_d;

	assign b       = in_data.in_byte;
	assign hx      = sed_hex(b);
	assign is_oct  = (b >= CH_ZERO) && (b <= CH_SEVEN);
	assign oct3    = {cv_q[5:0], b[2:0]};
	assign shifted = {cv_q, hx[3:0]};

	// Escape decode of the current word: main step, plain handling, flush.
	always_comb begin
		m_mode    = mode_q;
		m_cnt     = cnt_q;
		m_cv      = cv_q;
		hold_en   = 1'b0;
		ab_en     = 1'b0;
		ab_u      = 1'b0;
		ab_br     = 1'b0;
		ab_cnt    = cnt_q;
		val_en    = 1'b0;
		val_utf   = 1'b0;
		val_word  = {13'b0, b};
		plain_go  = 1'b0;
		tail_en   = 1'b0;
		tail_byte = b;
		case (mode_q)
			MODE_ESC: begin
				m_mode = MODE_PLAIN;
				val_en = 1'b1;
				case (b)
					CH_N: val_word = {13'b0, CTL_LF};
					CH_T: val_word = {13'b0, CTL_TAB};
					CH_R: val_word = {13'b0, CTL_CR};
					CH_V: val_word = {13'b0, CTL_VT};
					CH_F: val_word = {13'b0, CTL_FF};
					CH_B: val_word = {13'b0, CTL_BS};
					CH_X: begin
						val_en = 1'b0;
						m_mode = MODE_HEX;
						m_cnt  = '0;
						m_cv   = '0;
					end
					CH_U: begin
						val_en = 1'b0;
						m_mode = MODE_USTART;
						m_cnt  = '0;
						m_cv   = '0;
					end
					default: begin
						if (is_oct) begin
							val_en = 1'b0;
							m_mode = MODE_OCT;
							m_cv   = {18'b0, b[2:0]};
							m_cnt  = CW'(1);
						end
					end
				endcase
			end
			MODE_OCT: begin
				if (is_oct && cnt_q == CW'(1)) begin
					m_cv  = {12'b0, oct3};
					m_cnt = CW'(2);
				end else if (is_oct && cnt_q == CW'(2) && oct3 <= 9'd255) begin
					val_en   = 1'b1;
					val_word = {13'b0, oct3[7:0]};
					m_mode   = MODE_PLAIN;
					m_cnt    = '0;
					m_cv     = '0;
				end else begin
					val_en   = 1'b1;
					val_word = {13'b0, cv_q[7:0]};
					m_mode   = MODE_PLAIN;
					m_cnt    = '0;
					m_cv     = '0;
					plain_go = 1'b1;
				end
			end
			MODE_HEX: begin
				if (hx[4]) begin
					if (cnt_q >= CW'(1)) begin
						val_en   = 1'b1;
						val_word = {13'b0, cv_q[3:0], hx[3:0]};
						m_mode   = MODE_PLAIN;
						m_cnt    = '0;
						m_cv     = '0;
					end else begin
						hold_en = 1'b1;
					end
				end else begin
					ab_en    = 1'b1;
					m_mode   = MODE_PLAIN;
					m_cnt    = '0;
					m_cv     = '0;
					plain_go = 1'b1;
				end
			end
			MODE_USTART: begin
				if (b == CH_LBRACE) begin
					m_mode = MODE_UBRACE;
					m_cnt  = '0;
					m_cv   = '0;
				end else if (hx[4]) begin
					m_mode  = MODE_UFIXED;
					hold_en = 1'b1;
				end else begin
					ab_en    = 1'b1;
					ab_u     = 1'b1;
					m_mode   = MODE_PLAIN;
					m_cnt    = '0;
					m_cv     = '0;
					plain_go = 1'b1;
				end
			end
			MODE_UFIXED: begin
				if (hx[4]) begin
					if (cnt_q >= CW'(3)) begin
						val_en   = 1'b1;
						val_utf  = 1'b1;
						val_word = {cv_q[16:0], hx[3:0]};
						m_mode   = MODE_PLAIN;
						m_cnt    = '0;
						m_cv     = '0;
					end else begin
						hold_en = 1'b1;
					end
				end else begin
					ab_en    = 1'b1;
					ab_u     = 1'b1;
					m_mode   = MODE_PLAIN;
					m_cnt    = '0;
					m_cv     = '0;
					plain_go = 1'b1;
				end
			end
			MODE_UBRACE: begin
				if (b == CH_RBRACE) begin
					val_en   = 1'b1;
					val_utf  = 1'b1;
					val_word = cv_q;
					m_mode   = MODE_PLAIN;
					m_cnt    = '0;
					m_cv     = '0;
				end else if (hx[4] && cnt_q < CW'(MAX_BRACE_DIGITS)) begin
					hold_en = 1'b1;
				end else begin
					ab_en    = 1'b1;
					ab_u     = 1'b1;
					ab_br    = 1'b1;
					m_mode   = MODE_PLAIN;
					m_cnt    = '0;
					m_cv     = '0;
					plain_go = 1'b1;
				end
			end
			default: begin
				m_mode   = MODE_PLAIN;
				m_cnt    = '0;
				m_cv     = '0;
				plain_go = 1'b1;
			end
		endcase

		// A held digit extends the accumulator; oversized values saturate.
		if (hold_en) begin
			m_cnt = cnt_q + CW'(1);
			if (cv_q > CP_LIMIT || shifted > {4'b0, CP_LIMIT} || cv_q > CP_SHIFT_MAX) begin
				m_cv = CP_BAD;
			end else begin
				m_cv = shifted[20:0];
			end
		end

		// The current byte as fresh plain input.
		if (plain_go) begin
			if (b == CH_BSLASH) begin
				m_mode = MODE_ESC;
			end else begin
				tail_en = 1'b1;
			end
		end

		// End of body flushes whatever escape is still open.
		if (in_data.body_end) begin
			case (m_mode)
				MODE_ESC: begin
					tail_en   = 1'b1;
					tail_byte = CH_BSLASH;
				end
				MODE_OCT: begin
					val_en   = 1'b1;
					val_word = {13'b0, m_cv[7:0]};
				end
				MODE_HEX: begin
					ab_en  = 1'b1;
					ab_cnt = m_cnt;
				end
				MODE_USTART, MODE_UFIXED: begin
					ab_en  = 1'b1;
					ab_u   = 1'b1;
					ab_cnt = m_cnt;
				end
				MODE_UBRACE: begin
					ab_en  = 1'b1;
					ab_u   = 1'b1;
					ab_br  = 1'b1;
					ab_cnt = m_cnt;
				end
				default: begin
				end
			endcase
			m_mode = MODE_PLAIN;
			m_cnt  = '0;
			m_cv   = '0;
		end
	end

	// Result plan of the current word.
	assign utf = sed_utf8(val_word);

	always_comb begin
		plan_d          = '0;
		plan_d.ab_len   = ab_en ? (CNT_W'(1) + CNT_W'(ab_br) + CNT_W'(ab_cnt)) : '0;
		plan_d.val_len  = val_en ? (val_utf ? utf.len : 3'd1) : 3'd0;
		plan_d.tail_en  = tail_en;
		plan_d.body_end = in_data.body_end;
		val_d           = val_utf ? utf.bytes : {24'b0, val_word[7:0]};
	end

	// Escape state and plan registers, loaded when a word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			cnt_q  <= '0;
			cv_q   <= '0;
			plan_q <= '0;
		end else if (cmd.take) begin
			mode_q <= m_mode;
			cnt_q  <= m_cnt;
			cv_q   <= m_cv;
			plan_q <= plan_d;
		end
	end

	// Plan payload and held digits.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			letter_q <= ab_u ? CH_U : CH_X;
			brace_q  <= ab_br;
			val_q    <= val_d;
			tail_q   <= tail_byte;
			if (hold_en && cnt_q < CW'(MAX_BRACE_DIGITS)) begin
				held_q[cnt_q[DIW-1:0]] <= b;
			end
		end
	end

	// Result byte selection.
	logic [CNT_W-1:0] dig_pos;
	logic [7:0]       sel_byte;

	assign dig_pos = cmd.idx - CNT_W'(1) - CNT_W'(brace_q);

	always_comb begin
		case (cmd.seg)
			SEG_AB: begin
				if (cmd.idx == '0) begin
					sel_byte = letter_q;
				end else if (brace_q && cmd.idx == CNT_W'(1)) begin
					sel_byte = CH_LBRACE;
				end else begin
					sel_byte = held_q[dig_pos[DIW-1:0]];
				end
			end
			SEG_VAL:  sel_byte = val_q[cmd.idx[1:0]];
			SEG_TAIL: sel_byte = tail_q;
			default:  sel_byte = tail_q;
		endcase
	end

	// Output register: loads a byte when free or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.out_byte    <= sel_byte;
			out_q.run_last    <= cmd.last;
			out_q.string_done <= cmd.done;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_data       = out_q;
	assign stat.nxt       = plan_d;
	assign stat.cur       = plan_q;
	assign stat.slot_free = !out_valid_q || !out_stall;

endmodule

/* design/sed_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_checker: port checks of the string escape decoder
// Watches the top level ports for output word stability and for the
// ordering of result words against input acceptance.
// ----------------------------------------------------------------------------
module sed_checker
	import sed_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     src_valid,
	input logic     src_stall,
	input logic     dst_valid,
	input logic     dst_stall,
	input sed_out_t dst_data
);

	// A stalled output word stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
		else $error("output word changed while stalled");

	// The final word of a string is also the last word of its input byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.string_done |-> dst_data.run_last)
		else $error("string_done without run_last");

	// While a word that is not the last of its run waits, input is held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_data.run_last |-> src_stall)
		else $error("input open while a result run is unfinished");

	// The input side stalls only after it has taken a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(src_stall) |-> $past(src_valid))
		else $error("input stall rose without an accepted word");

endmodule

bind string_escape_decoder_core sed_checker u_sed_checker (.*);
